FILE: rtl/u8s_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the UTF-8 sanitizer.
package u8s_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] REPL_BYTE0 = 8'hEF;
   localparam logic [7:0] REPL_BYTE1 = 8'hBF;
   localparam logic [7:0] REPL_BYTE2 = 8'hBD;
   localparam logic [1:0] REPL_LAST_IDX = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       text_end;
   } rsp_payload_type;

   // One burst of output bytes: data[0] goes out first, data[last_idx] last.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            text_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Lead byte class; the encoding equals the claimed sequence length.
   typedef enum logic [2:0] {
      CLASS_STRAY = 3'd0,
      CLASS_ONE   = 3'd1,
      CLASS_TWO   = 3'd2,
      CLASS_THREE = 3'd3,
      CLASS_FOUR  = 3'd4
   } lead_class_type;

   function automatic lead_class_type classify(logic [7:0] b);
      lead_class_type cls;
      if ((b & 8'h80) == 8'h00) cls = CLASS_ONE;
      else if ((b & 8'hE0) == 8'hC0) cls = CLASS_TWO;
      else if ((b & 8'hF0) == 8'hE0) cls = CLASS_THREE;
      else if ((b & 8'hF8) == 8'hF0) cls = CLASS_FOUR;
      else cls = CLASS_STRAY;
      return cls;
   endfunction

   function automatic cmd_type repl_cmd(logic text_last);
      cmd_type cmd;
      cmd           = '0;
      cmd.data[0]   = REPL_BYTE0;
      cmd.data[1]   = REPL_BYTE1;
      cmd.data[2]   = REPL_BYTE2;
      cmd.last_idx  = REPL_LAST_IDX;
      cmd.text_last = text_last;
      return cmd;
   endfunction

endpackage

FILE: rtl/u8s_front.sv
`timescale 1ns / 1ps
// Front end: accepts request bytes, tracks open sequences, queues output bursts.
module u8s_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  u8s_pkg::req_payload_type  req_payload,
   input  u8s_pkg::queue_status_type q_status,
   output logic                      push,
   output u8s_pkg::cmd_type          push_cmd
);
   import u8s_pkg::*;

   logic [7:0]     seq_ff [3];
   logic [7:0]     seq_in [3];
   logic [1:0]     rem_ff, rem_in;
   logic [2:0]     len_ff, len_in;
   logic           good_ff, good_in;

   logic           accept;
   logic [7:0]     cur;
   lead_class_type cls;
   logic [2:0]     pos;
   logic           good_next;
   logic [1:0]     rem_dec;
   logic [1:0]     tail_idx;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;
   assign cur       = req_payload.in_byte;
   assign cls       = classify(cur);
   assign pos       = len_ff - {1'b0, rem_ff};
   assign good_next = good_ff & (cur[7:6] == 2'b10);
   assign rem_dec   = rem_ff - 2'd1;
   assign tail_idx  = 2'(len_ff - 3'd1);

   always_comb begin
      seq_in   = seq_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      good_in  = good_ff;
      push     = 1'b0;
      push_cmd = '0;
      push_cmd.text_last = req_payload.text_last;
      if (accept) begin
         if (rem_ff == 2'd0) begin
            unique case (cls)
               CLASS_ONE: begin
                  push             = 1'b1;
                  push_cmd.data[0] = cur;
               end
               CLASS_TWO, CLASS_THREE, CLASS_FOUR: begin
                  seq_in[0] = cur;
                  if (req_payload.text_last) begin
                     // sequence cut short: replace and drop
                     push     = 1'b1;
                     push_cmd = repl_cmd(req_payload.text_last);
                  end else begin
                     len_in  = 3'(cls);
                     rem_in  = 2'(3'(cls) - 3'd1);
                     good_in = 1'b1;
                  end
               end
               default: begin
                  // stray lead byte
                  push     = 1'b1;
                  push_cmd = repl_cmd(req_payload.text_last);
               end
            endcase
         end else begin
            if (pos < 3'd3) seq_in[pos[1:0]] = cur;
            rem_in  = rem_dec;
            good_in = good_next;
            if (rem_dec == 2'd0) begin
               push = 1'b1;
               if (good_next) begin
                  push_cmd.data[0]        = seq_ff[0];
                  push_cmd.data[1]        = seq_ff[1];
                  push_cmd.data[2]        = seq_ff[2];
                  push_cmd.data[3]        = cur;
                  push_cmd.data[tail_idx] = cur;
                  push_cmd.last_idx       = tail_idx;
               end else begin
                  push_cmd = repl_cmd(req_payload.text_last);
               end
               rem_in  = 2'd0;
               len_in  = 3'd0;
               good_in = 1'b1;
            end else if (req_payload.text_last) begin
               push     = 1'b1;
               push_cmd = repl_cmd(req_payload.text_last);
               rem_in   = 2'd0;
               len_in   = 3'd0;
               good_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= 2'd0;
         len_ff  <= 3'd0;
         good_ff <= 1'b1;
      end else begin
         rem_ff  <= rem_in;
         len_ff  <= len_in;
         good_ff <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
   end

endmodule

FILE: rtl/u8s_queue.sv
`timescale 1ns / 1ps
// Command queue between the front end and the output sequencer.
module u8s_queue #(
   parameter int DEPTH = u8s_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  u8s_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output u8s_pkg::cmd_type          head,
   output u8s_pkg::queue_status_type status
);
   import u8s_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: rtl/u8s_back.sv
`timescale 1ns / 1ps
// Output sequencer: plays queued bursts into the rsp register one byte per cycle while rsp is not stalled.
module u8s_back (
   input  logic                      clock,
   input  logic                      reset,
   input  u8s_pkg::cmd_type          head,
   input  u8s_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output u8s_pkg::rsp_payload_type  rsp_payload
);
   import u8s_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [1:0]      idx_ff, idx_in;
   logic            load;
   logic            at_last;

   assign load    = ~rsp_valid_ff | ~rsp_stall;
   assign at_last = (idx_ff == head.last_idx);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      idx_in         = idx_ff;
      pop            = 1'b0;
      if (load) begin
         rsp_valid_in = ~q_status.empty;
         if (!q_status.empty) begin
            rsp_payload_in.out_byte = head.data[idx_ff];
            rsp_payload_in.run_end  = at_last;
            rsp_payload_in.text_end = at_last & head.text_last;
            if (at_last) begin
               // burst done: release the queue entry
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/utf8_sanitizer.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 sanitizer: front end, command queue and output sequencer.
//
//   channel   ports                                 direction  carries
//   req       req_valid req_stall req_payload       in         raw text byte, last mark
//   rsp       rsp_valid rsp_stall rsp_payload       out        sanitized byte, run/text end
//
// One request byte is taken per cycle while the command queue has room.
// The output sequencer plays each burst out byte by byte: a replacement is three bytes,
// a completed N-byte sequence N bytes, so sustained bursts fill the queue and stall requests.
// An accepted byte is written into the command queue, and the output sequencer loads it from there into rsp.
// Reset is synchronous and clears the sequence state, queue and rsp valid; no clearing pass.
// rsp_stall holds the rsp register; the queue keeps absorbing requests until full.
module utf8_sanitizer #(
   parameter int QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  u8s_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output u8s_pkg::rsp_payload_type rsp_payload
);
   import u8s_pkg::*;

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head;

   u8s_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   u8s_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   u8s_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/u8s_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the UTF-8 sanitizer and its bind to the top level.
module u8s_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input u8s_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input u8s_pkg::rsp_payload_type rsp_payload
);
   import u8s_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // drop valid only after a completed handshake
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("response withdrawn while stalled");

   // text end closes a run
   a_text_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.text_end |-> rsp_payload.run_end)
      else $error("text end without run end");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind utf8_sanitizer u8s_checker u_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 sanitizer: directed and random text streams.
module tb;
   import u8s_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   // predictor state
   logic [7:0] held_bytes [3];
   logic [1:0] cont_left = 2'd0;
   logic [2:0] seq_len = 3'd0;
   logic       cont_ok = 1'b1;

   rsp_payload_type sanitized_q [$];

   utf8_sanitizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic lead_class_type lead_class_of(logic [7:0] b);
      lead_class_type cls;
      casez (b)
         8'b0???????: cls = CLASS_ONE;
         8'b110?????: cls = CLASS_TWO;
         8'b1110????: cls = CLASS_THREE;
         8'b11110???: cls = CLASS_FOUR;
         default:     cls = CLASS_STRAY;
      endcase
      return cls;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] ERROR %s", $realtime, what);
      mismatch_count++;
   endtask

   // Work out the bytes one accepted request yields and queue them.
   task automatic predict_sanitized(input logic [7:0] b, input logic last);
      logic [7:0]     outb [$];
      lead_class_type cls;
      logic [2:0]     pos;
      logic           replace;
      logic           close_seq;
      rsp_payload_type item;
      int             i;
      replace = 1'b0;
      close_seq = 1'b0;
      if (cont_left == 2'd0) begin
         cls = lead_class_of(b);
         case (cls)
            CLASS_ONE: begin
               outb = {outb, b};
            end
            CLASS_STRAY: begin
               replace = 1'b1;
            end
            default: begin
               held_bytes[0] = b;
               seq_len = cls;
               cont_left = 2'(seq_len - 3'd1);
               cont_ok = 1'b1;
               if (last) begin
                  replace = 1'b1;
                  close_seq = 1'b1;
               end
            end
         endcase
      end else begin
         pos = seq_len - {1'b0, cont_left};
         if (pos < 3'd3) held_bytes[pos[1:0]] = b;
         if (b[7:6] != 2'b10) cont_ok = 1'b0;
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            if (cont_ok) begin
               for (i = 0; i < int'(seq_len) - 1; i++) outb = {outb, held_bytes[i]};
               outb = {outb, b};
            end else begin
               replace = 1'b1;
            end
            close_seq = 1'b1;
         end else if (last) begin
            replace = 1'b1;
            close_seq = 1'b1;
         end
      end
      if (replace) begin
         outb = {outb, REPL_BYTE0, REPL_BYTE1, REPL_BYTE2};
      end
      if (close_seq) begin
         cont_left = 2'd0;
         seq_len = 3'd0;
         cont_ok = 1'b1;
      end
      for (i = 0; i < outb.size(); i++) begin
         item.out_byte = outb[i];
         item.run_end  = (i == outb.size() - 1);
         item.text_end = (i == outb.size() - 1) && last;
         sanitized_q = {sanitized_q, item};
      end
   endtask

   // Enter after a rising edge; return right after the edge that takes the request.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_byte: b, text_last: last};
      do @(posedge clock); while (req_stall);
      predict_sanitized(b, last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sanitized_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_payload.out_byte));
         end else begin
            if (rsp_payload.out_byte !== sanitized_q[0].out_byte)
               report_mismatch($sformatf("out_byte got %02h want %02h",
                                         rsp_payload.out_byte, sanitized_q[0].out_byte));
            if (rsp_payload.run_end !== sanitized_q[0].run_end)
               report_mismatch($sformatf("run_end got %b want %b (byte %02h)",
                                         rsp_payload.run_end, sanitized_q[0].run_end,
                                         sanitized_q[0].out_byte));
            if (rsp_payload.text_end !== sanitized_q[0].text_end)
               report_mismatch($sformatf("text_end got %b want %b (byte %02h)",
                                         rsp_payload.text_end, sanitized_q[0].text_end,
                                         sanitized_q[0].out_byte));
            void'(sanitized_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d bytes outstanding", sanitized_q.size());
         $display("utf8_sanitizer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed_cases();
      // plain ASCII extremes, the second ends a text
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      // stray lead bytes, one closing a text
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b1);
      // well-formed two, three and four byte sequences
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b1);
      // bad continuation still consumes the claimed length
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      // cut short by end of text, then a lone lead at end of text
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'hF7, 1'b1);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
   endtask

   task automatic test_random_text(input int n_bytes, input int send_pct, input int recv_pct);
      logic [7:0] unit_q [$];
      int         sent;
      int         kind;
      int         len;
      int         k;
      logic       end_text;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < n_bytes) begin
         unit_q.delete();
         kind = $urandom_range(9);
         len = $urandom_range(1, 4);
         if (kind >= 8) begin
            unit_q = {unit_q, 8'($urandom)};
         end else begin
            case (len)
               1: unit_q = {unit_q, {1'b0, 7'($urandom)}};
               2: unit_q = {unit_q, {3'b110, 5'($urandom)}};
               3: unit_q = {unit_q, {4'b1110, 4'($urandom)}};
               default: unit_q = {unit_q, {5'b11110, 3'($urandom)}};
            endcase
            for (k = 1; k < len; k++) unit_q = {unit_q, {2'b10, 6'($urandom)}};
            // break one continuation
            if (kind == 6 && len > 1)
               unit_q[$urandom_range(1, len - 1)] = 8'($urandom);
         end
         // truncate: drop trailing bytes and end the text mid-sequence
         if (kind == 7 && len > 1) begin
            k = $urandom_range(1, len - 1);
            while (unit_q.size() > k) void'(unit_q.pop_back());
            end_text = 1'b1;
         end else begin
            end_text = ($urandom_range(7) == 0);
         end
         for (k = 0; k < unit_q.size(); k++)
            send_byte(unit_q[k], end_text && (k == unit_q.size() - 1));
         sent += unit_q.size();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9;
      recv_idle_pct = 50;
      test_directed_cases();
      test_random_text(70, 9, 50);
      test_random_text(70, 50, 9);
      test_random_text(70, 0, 0);
      // close any open sequence so nothing stays buffered
      send_byte(8'h41, 1'b1);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sanitized_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("utf8_sanitizer: match");
      else
         $display("utf8_sanitizer: mismatch");
      $finish;
   end

endmodule
